FILE: sv/mtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front coder package
// Shared widths, defaults and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int BYTE_W           = 8;
  localparam int SYMBOL_COUNT_DEF = 256;

  // Commands from the controller to the datapath, at most one step a cycle.
  typedef struct packed {
    logic start;     // capture an accepted item and aim the read pointer
    logic fetch;     // decode: list entry at the position is being read
    logic pick;      // decode: the picked symbol arrives from the list
    logic prime;     // encode: the first list entry is being read
    logic scan;      // shift one entry back and test for the stop point
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic in_range;  // the offered byte is a valid symbol or position
    logic decode;    // current coding direction
    logic hit;       // the scan has reached the entry that moves to the front
    logic out_free;  // the output register can take a result this cycle
  } status_t;

endpackage

FILE: sv/mtf_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front coder channels
// Valid/ready channel interfaces for the input, result and configuration.
// ----------------------------------------------------------------------------
interface mtf_in_if import mtf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              block_end;

  modport source (output valid, in_byte, block_end, input ready);
  modport sink   (input valid, in_byte, block_end, output ready);
endinterface

interface mtf_out_if import mtf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              block_end_out;

  modport source (output valid, out_byte, block_end_out, input ready);
  modport sink   (input valid, out_byte, block_end_out, output ready);
endinterface

interface mtf_cfg_if;
  logic valid;
  logic ready;
  logic decode_mode;

  modport source (output valid, decode_mode, input ready);
  modport sink   (input valid, decode_mode, output ready);
endinterface

FILE: sv/mtf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front coder datapath
// Symbol list memory with per-entry valid bits, the scan pointer, the carry
// register that shifts entries back, the mode register and the output stage.
// ----------------------------------------------------------------------------
module mtf_datapath import mtf_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              block_end,
  input  logic              cfg_valid,
  input  logic              cfg_decode_mode,
  input  cmd_t              cmd,
  input  logic              out_ready,
  output status_t           status,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              block_end_out
);

  localparam int              ADDR_W    = $clog2(SYMBOL_COUNT);
  localparam logic [BYTE_W:0] SYM_LIMIT = (BYTE_W + 1)'(SYMBOL_COUNT);

  logic [BYTE_W-1:0]       mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r;

  logic              mode_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [BYTE_W-1:0] rd_word_r;
  logic              rd_valid_r;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] byte_r;
  logic              end_r;
  logic [BYTE_W-1:0] carry_r;
  logic [BYTE_W-1:0] res_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;

  // An entry never written still holds its identity value.
  assign rd_data = rd_valid_r ? rd_word_r : BYTE_W'(rd_addr_r);

  assign status.in_range = ({1'b0, in_byte} < SYM_LIMIT);
  assign status.decode   = mode_r;
  assign status.hit      = mode_r ? (rd_addr_r == byte_r[ADDR_W-1:0]) : (rd_data == byte_r);
  assign status.out_free = !out_valid_r || out_ready;

  // The list memory: one read at the pointer, one write behind it.
  always_ff @(posedge clk) begin
    rd_word_r <= mem[ptr_r];
    rd_addr_r <= ptr_r;
    if (cmd.scan) begin
      mem[rd_addr_r] <= carry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[ptr_r];
      if (cmd.scan) begin
        valid_r[rd_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_decode_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr_r   <= mode_r ? in_byte[ADDR_W-1:0] : '0;
      byte_r  <= in_byte;
      end_r   <= block_end;
      carry_r <= in_byte;
      res_r   <= '0;
    end else if (cmd.fetch) begin
      ptr_r <= '0;
    end else if (cmd.pick) begin
      ptr_r   <= ptr_r + 1'b1;
      carry_r <= rd_data;
      res_r   <= rd_data;
    end else if (cmd.prime) begin
      ptr_r <= ptr_r + 1'b1;
    end else if (cmd.scan) begin
      ptr_r   <= ptr_r + 1'b1;
      carry_r <= rd_data;
      if (status.hit && !mode_r) begin
        res_r <= BYTE_W'(rd_addr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= res_r;
      out_end_r  <= end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign block_end_out = out_end_r;

endmodule

FILE: sv/mtf_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front coder controller
// Sequences one item at a time: fetch, scan and shift, then hand off.
// ----------------------------------------------------------------------------
module mtf_controller import mtf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FETCH  = 6'b000010,
    ST_PICK   = 6'b000100,
    ST_PRIME  = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (!status.in_range) begin
            state_nxt = ST_FINISH;
          end else if (status.decode) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One item at a time: an accepted item closes the input until it is done.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output register loaded while occupied");

  // The scan ends at the entry that moves to the front.
  a_scan_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && status.hit) |=> (state_r == ST_FINISH))
    else $error("scan did not stop at its hit");

endmodule

FILE: sv/move_to_front_coder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front coder
// Byte-wise move-to-front encoder and decoder over one shared symbol list.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one byte and a block-end flag per transfer. In encode mode
//   the byte is a symbol and out_ch returns its list position; in decode mode
//   the byte is a position and out_ch returns the symbol held there. Either
//   way that symbol then moves to the front of the list. Every input transfer
//   yields exactly one output transfer, with block_end_out copied through.
//   cfg_ch writes decode_mode; it is always ready and should only be written
//   while no item is in flight.
// Timing:
//   Items are handled one at a time by a scan over the list memory, one entry
//   per cycle through its single read and write port. An item whose symbol
//   sits at list position k is scanned from entry 0 through entry k; a decode item
//   first reads its position, and an out-of-range byte skips the scan.
//   Input reopens once the result lands in the output register, even if the
//   receiver has not yet taken it, so the next item is scanned meanwhile.
// Reset:
//   The list returns to identity order at once through per-entry valid bits
//   and decode_mode returns to encode. The list is kept across block ends.
//   A stalled receiver holds the result; the block then waits to finish.
// ----------------------------------------------------------------------------
module move_to_front_coder_top import mtf_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  mtf_in_if.sink   in_ch,
  mtf_out_if.source out_ch,
  mtf_cfg_if.sink  cfg_ch
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // Configuration writes land in a single register and never stall.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  mtf_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mtf_datapath #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_ch.in_byte),
    .block_end       (in_ch.block_end),
    .cfg_valid       (cfg_ch.valid),
    .cfg_decode_mode (cfg_ch.decode_mode),
    .cmd             (cmd),
    .out_ready       (out_ch.ready),
    .status          (status),
    .out_valid       (out_ch.valid),
    .out_byte        (out_ch.out_byte),
    .block_end_out   (out_ch.block_end_out)
  );

endmodule
